// File: src/ssl_pkg.sv
// shared constants, register codes and record header type for the sensor stats logger
package ssl_pkg;

  localparam int unsigned TempW    = 16;
  localparam int unsigned BattW    = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned SizeW    = 25;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 25;

  localparam int unsigned AvgDepthDef    = 8;
  localparam int unsigned RecordBytesDef = 32;

  localparam logic [CntW-1:0]  SamplePeriodRst = 16'd9;
  localparam logic [CntW-1:0]  LogPeriodRst    = 16'd59;
  localparam logic [AddrW-1:0] BaseAddrRst     = 24'd0;
  localparam logic [SizeW-1:0] MemSizeRst      = 25'd1048576;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSamplePeriod = 2'd0,
    CfgLogPeriod    = 2'd1,
    CfgBaseAddr     = 2'd2,
    CfgMemSize      = 2'd3
  } cfg_idx_e;

  // everything a record carries except the ring mean
  typedef struct packed {
    logic        [AddrW-1:0] write_address;
    logic signed [TempW-1:0] min_temp;
    logic signed [TempW-1:0] max_temp;
    logic        [BattW-1:0] battery;
    logic                    mains_failed;
    logic                    charging;
    logic                    compressor;
    logic                    fan;
  } rec_hdr_t;

endpackage

// File: src/ssl_if.sv
// snapshot and record channel interfaces
interface ssl_in_if import ssl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_a;
  logic signed [TempW-1:0] temp_b;
  logic signed [TempW-1:0] temp_c;
  logic signed [TempW-1:0] temp_d;
  logic        [BattW-1:0] battery_in;
  logic                    mains_failed_in;
  logic                    charging_in;
  logic                    compressor_in;
  logic                    fan_in;

  modport source (
    output valid, temp_a, temp_b, temp_c, temp_d, battery_in,
           mains_failed_in, charging_in, compressor_in, fan_in,
    input  ready
  );
  modport sink (
    input  valid, temp_a, temp_b, temp_c, temp_d, battery_in,
           mains_failed_in, charging_in, compressor_in, fan_in,
    output ready
  );
endinterface

interface ssl_out_if import ssl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [AddrW-1:0] write_address;
  logic signed [TempW-1:0] min_temp_out;
  logic signed [TempW-1:0] max_temp_out;
  logic signed [TempW-1:0] avg_temp_out;
  logic        [BattW-1:0] battery_out;
  logic                    mains_failed_out;
  logic                    charging_out;
  logic                    compressor_out;
  logic                    fan_out;

  modport source (
    output valid, write_address, min_temp_out, max_temp_out, avg_temp_out,
           battery_out, mains_failed_out, charging_out, compressor_out, fan_out,
    input  ready
  );
  modport sink (
    input  valid, write_address, min_temp_out, max_temp_out, avg_temp_out,
           battery_out, mains_failed_out, charging_out, compressor_out, fan_out,
    output ready
  );
endinterface

// File: src/ssl_ram.sv
// generic single write port ram with registered read
module ssl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/ssl_fifo.sv
// two entry queue between front and back
module ssl_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] ent_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= wdata_i;
    end
  end
endmodule

// File: src/ssl_front.sv
// front end: takes snapshots, tracks min/max, ring, running ring sum, periods, address
module ssl_front import ssl_pkg::*; #(
  parameter int unsigned AVG_DEPTH    = AvgDepthDef,
  parameter int unsigned RECORD_BYTES = RecordBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ssl_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output rec_hdr_t            hdr_o,
  output logic [SumW-1:0]     sum_o
);
  localparam int unsigned SumW  = TempW + $clog2(AVG_DEPTH);
  localparam int unsigned SlotW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  logic [CntW-1:0]  sample_period_q, log_period_q;
  logic [AddrW-1:0] base_q;
  logic [SizeW-1:0] mem_size_q;

  logic [CntW-1:0]  sample_cnt_q, log_cnt_q;
  logic [SlotW-1:0] slot_q, slot_nxt;
  logic [AVG_DEPTH-1:0] vld_q;
  logic             old_vld_q;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [TempW-1:0] min_q, max_q, min_d, max_d;
  logic [AddrW-1:0] next_q, next_d;
  logic             gap_q;

  logic             accept, sample_hit, log_hit;
  logic signed [TempW-1:0] tv [4];
  logic signed [17:0] s4, s4_adj;
  logic signed [TempW-1:0] avg4;
  logic [TempW-1:0] ram_rdata;
  logic signed [TempW-1:0] old_val;
  logic [SizeW-1:0] addr_inc;

  // ready drops after each accepted word so the ring read port can fetch the next slot
  assign in_i.ready = !gap_q && !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign sample_hit = (sample_cnt_q >= sample_period_q);
  assign log_hit    = (log_cnt_q >= log_period_q);

  assign tv[0] = in_i.temp_a;
  assign tv[1] = in_i.temp_b;
  assign tv[2] = in_i.temp_c;
  assign tv[3] = in_i.temp_d;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    for (int i = 0; i < 4; i++) begin
      if (tv[i] < min_d) min_d = tv[i];
      if (tv[i] > max_d) max_d = tv[i];
    end
  end

  // mean of four, truncated toward zero
  always_comb begin
    s4     = 18'(tv[0]) + 18'(tv[1]) + 18'(tv[2]) + 18'(tv[3]);
    s4_adj = s4 + (s4[17] ? 18'sd3 : 18'sd0);
    avg4   = s4_adj[17:2];
  end

  ssl_ram #(
    .WIDTH (TempW),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && sample_hit),
    .waddr_i (slot_q),
    .wdata_i (avg4),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign old_val  = old_vld_q ? $signed(ram_rdata) : '0;
  assign slot_nxt = (slot_q == SlotW'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_comb begin
    sum_d = sum_q;
    if (sample_hit) begin
      sum_d = sum_q + SumW'(avg4) - SumW'(old_val);
    end
  end

  always_comb begin
    addr_inc = {1'b0, next_q} + SizeW'(RECORD_BYTES);
    if (addr_inc >= mem_size_q) begin
      next_d = base_q + AddrW'(RECORD_BYTES);
    end else begin
      next_d = addr_inc[AddrW-1:0];
    end
  end

  assign push_o              = accept && log_hit;
  assign hdr_o.write_address = next_q;
  assign hdr_o.min_temp      = min_d;
  assign hdr_o.max_temp      = max_d;
  assign hdr_o.battery       = in_i.battery_in;
  assign hdr_o.mains_failed  = in_i.mains_failed_in;
  assign hdr_o.charging      = in_i.charging_in;
  assign hdr_o.compressor    = in_i.compressor_in;
  assign hdr_o.fan           = in_i.fan_in;
  assign sum_o               = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= SamplePeriodRst;
      log_period_q    <= LogPeriodRst;
      base_q          <= BaseAddrRst;
      mem_size_q      <= MemSizeRst;
      sample_cnt_q    <= '0;
      log_cnt_q       <= '0;
      slot_q          <= '0;
      vld_q           <= '0;
      old_vld_q       <= 1'b0;
      sum_q           <= '0;
      min_q           <= '0;
      max_q           <= '0;
      next_q          <= BaseAddrRst;
      gap_q           <= 1'b0;
    end else begin
      gap_q     <= accept;
      old_vld_q <= vld_q[slot_q];
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgSamplePeriod: sample_period_q <= cfg_data_i[CntW-1:0];
          CfgLogPeriod:    log_period_q    <= cfg_data_i[CntW-1:0];
          CfgBaseAddr: begin
            base_q <= cfg_data_i[AddrW-1:0];
            next_q <= cfg_data_i[AddrW-1:0];
          end
          CfgMemSize:      mem_size_q      <= cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        min_q <= min_d;
        max_q <= max_d;
        sum_q <= sum_d;
        if (sample_hit) begin
          vld_q[slot_q] <= 1'b1;
          slot_q        <= slot_nxt;
          sample_cnt_q  <= '0;
        end else begin
          sample_cnt_q  <= sample_cnt_q + 1'b1;
        end
        if (log_hit) begin
          next_q    <= next_d;
          log_cnt_q <= '0;
        end else begin
          log_cnt_q <= log_cnt_q + 1'b1;
        end
      end
    end
  end
endmodule

// File: src/ssl_back.sv
// back end: divides the ring sum by the depth and holds the record for output
module ssl_back import ssl_pkg::*; #(
  parameter int unsigned AVG_DEPTH = AvgDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  rec_hdr_t        job_hdr_i,
  input  logic [SumW-1:0] job_sum_i,
  output logic            pop_o,
  ssl_out_if.source       out_o
);
  localparam int unsigned SumW     = TempW + $clog2(AVG_DEPTH);
  localparam int unsigned DivShift = SumW + $clog2(AVG_DEPTH);
  localparam int unsigned ProdW    = 2 * SumW + 1;
  // rounded-up reciprocal, exact floor division for any SumW-bit magnitude
  localparam longint unsigned RecipFull =
    ((longint'(1) << DivShift) + longint'(AVG_DEPTH) - 1) / longint'(AVG_DEPTH);
  localparam logic [SumW:0] Recip = (SumW + 1)'(RecipFull);

  logic             v1_q, v2_q, vo_q;
  rec_hdr_t         hdr1_q, hdr2_q, hdro_q;
  logic             neg1_q, neg2_q;
  logic [SumW-1:0]  mag1_q;
  logic [ProdW-1:0] prod2_q;
  logic signed [TempW-1:0] avgo_q;
  logic [TempW-1:0] quo;
  logic             adv1, adv2, free1, free2, freeo;

  assign freeo = !vo_q || out_o.ready;
  assign adv2  = v2_q && freeo;
  assign free2 = !v2_q || adv2;
  assign adv1  = v1_q && free2;
  assign free1 = !v1_q || adv1;
  assign pop_o = job_valid_i && free1;

  assign quo = prod2_q[DivShift +: TempW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (free1) v1_q <= job_valid_i;
      if (free2) v2_q <= v1_q;
      if (freeo) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hdr1_q <= job_hdr_i;
      neg1_q <= job_sum_i[SumW-1];
      mag1_q <= job_sum_i[SumW-1] ? (~job_sum_i + 1'b1) : job_sum_i;
    end
    if (adv1) begin
      hdr2_q  <= hdr1_q;
      neg2_q  <= neg1_q;
      prod2_q <= ProdW'(mag1_q) * ProdW'(Recip);
    end
    if (adv2) begin
      hdro_q <= hdr2_q;
      avgo_q <= neg2_q ? $signed(~quo + 1'b1) : $signed(quo);
    end
  end

  assign out_o.valid            = vo_q;
  assign out_o.write_address    = hdro_q.write_address;
  assign out_o.min_temp_out     = hdro_q.min_temp;
  assign out_o.max_temp_out     = hdro_q.max_temp;
  assign out_o.avg_temp_out     = avgo_q;
  assign out_o.battery_out      = hdro_q.battery;
  assign out_o.mains_failed_out = hdro_q.mains_failed;
  assign out_o.charging_out     = hdro_q.charging;
  assign out_o.compressor_out   = hdro_q.compressor;
  assign out_o.fan_out          = hdro_q.fan;
endmodule

// File: src/sensor_stats_logger_unit.sv
// sensor stats logger top level: front end, record queue and divide/output back end
// input: ready drops after each accepted snapshot word and while the record queue is full;
//   the gap lets the single ring read port fetch the entry that the next ring write overwrites
// record path: the record queue, then the back end's magnitude, product and output registers
// the 2-entry record queue lets the front keep taking words while output is stalled, until it fills
// reset: registers to defaults, counts/min/max/ring sum/slot zero, ring valid bits clear
//   (unwritten ring entries read as zero), write address = base address
module sensor_stats_logger_unit import ssl_pkg::*; #(
  parameter int unsigned AVG_DEPTH    = AvgDepthDef,
  parameter int unsigned RECORD_BYTES = RecordBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ssl_in_if.sink              in_i,
  ssl_out_if.source           out_o
);
  // ring sum needs log2 of the depth extra bits over one temperature
  localparam int unsigned SumW = TempW + $clog2(AVG_DEPTH);
  localparam int unsigned HdrW = $bits(rec_hdr_t);
  localparam int unsigned JobW = HdrW + SumW;

  // front to queue
  logic            push, full;
  rec_hdr_t        push_hdr;
  logic [SumW-1:0] push_sum;

  // queue to back
  logic            job_valid, pop;
  logic [JobW-1:0] job_word;
  rec_hdr_t        job_hdr;
  logic [SumW-1:0] job_sum;

  // snapshot side: stats, ring and address bookkeeping all happen at accept
  ssl_front #(
    .AVG_DEPTH    (AVG_DEPTH),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .hdr_o      (push_hdr),
    .sum_o      (push_sum)
  );

  // pending records: header plus ring sum still to be divided
  ssl_fifo #(
    .WIDTH (JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_hdr, push_sum}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (job_word)
  );

  assign job_hdr = rec_hdr_t'(job_word[SumW +: HdrW]);
  assign job_sum = job_word[SumW-1:0];

  // record side: reciprocal multiply for the mean, then the output register
  ssl_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_hdr_i   (job_hdr),
    .job_sum_i   (job_sum),
    .pop_o       (pop),
    .out_o       (out_o)
  );
endmodule

// File: dv/sensor_stats_logger_unit_tb.sv
// self-checking testbench for the sensor stats logger top level
module sensor_stats_logger_unit_tb;
  import ssl_pkg::*;

  // ring depth and record stride as signed ints so that the mean divides toward zero
  localparam int RingDepth = AvgDepthDef;
  localparam int RecBytes  = RecordBytesDef;

  // cycles to let a word with no record finish inside the block
  localparam int unsigned Settle      = 8;
  localparam int unsigned RandomItems = 1830;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned CycleLimit  = 1_000_000;

  // one snapshot word; flags are {mains_failed, charging, compressor, fan}
  typedef struct packed {
    logic signed [TempW-1:0] ta;
    logic signed [TempW-1:0] tb;
    logic signed [TempW-1:0] tc;
    logic signed [TempW-1:0] td;
    logic        [BattW-1:0] batt;
    logic        [3:0]       flags;
  } snap_t;

  // one log record word, flags in the same order as above
  typedef struct packed {
    logic        [AddrW-1:0] addr;
    logic signed [TempW-1:0] tmin;
    logic signed [TempW-1:0] tmax;
    logic signed [TempW-1:0] tavg;
    logic        [BattW-1:0] batt;
    logic        [3:0]       flags;
  } rec_t;

  // a row of the directed table: either a register write or a snapshot,
  // the snapshot optionally carrying a hand-written expected record
  typedef enum logic {StepCfg, StepSnap} step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    cfg_idx_e            reg_sel;
    logic [CfgDataW-1:0] value;
    snap_t               snap;
    logic                typed;
    rec_t                want;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ssl_in_if  snap_ch ();
  ssl_out_if rec_ch ();

  sensor_stats_logger_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (snap_ch),
    .out_o      (rec_ch)
  );

  // ---------------------------------------------------------------------------
  // logger model state: register copies, counters, mean ring, extremes, address
  // ---------------------------------------------------------------------------
  int unsigned sample_every;
  int unsigned log_every;
  int unsigned base_addr;
  int unsigned mem_limit;
  int unsigned samples_since;
  int unsigned logs_since;
  int          mean_ring [RingDepth];
  int          ring_wr;
  int          temp_lo;
  int          temp_hi;
  int unsigned next_addr;

  // records still owed by the block, oldest first
  rec_t pending_records [$];

  int unsigned snapshots_sent;
  int unsigned records_checked;
  int unsigned reg_writes;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  // idling controls, switched per phase
  bit src_gaps;
  bit sink_stalls;

  // mirror a register write into the model; a base write also restarts the address
  function automatic void apply_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    case (idx)
      CfgSamplePeriod: begin
        sample_every = v[CntW-1:0];
      end
      CfgLogPeriod: begin
        log_every = v[CntW-1:0];
      end
      CfgBaseAddr: begin
        base_addr = v[AddrW-1:0];
        next_addr = base_addr;
      end
      CfgMemSize: begin
        mem_limit = v[SizeW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // advance the logger model by one snapshot; returns 1 with the record when one is due
  function automatic bit predict_record(input snap_t s, output rec_t r);
    int          temps [4];
    int          quad_sum;
    int          ring_sum;
    int          mean;
    int unsigned nxt;
    temps = '{$signed(s.ta), $signed(s.tb), $signed(s.tc), $signed(s.td)};
    quad_sum = 0;
    r = '0;
    // extremes include the reset zero, never cleared
    foreach (temps[i]) begin
      if (temps[i] > temp_hi) temp_hi = temps[i];
      if (temps[i] < temp_lo) temp_lo = temps[i];
      quad_sum += temps[i];
    end
    // ring sample: four-way mean, truncated toward zero
    if (samples_since >= sample_every) begin
      mean_ring[ring_wr] = quad_sum / 4;
      ring_wr = (ring_wr + 1) % RingDepth;
      samples_since = 0;
    end else begin
      samples_since++;
    end
    if (logs_since < log_every) begin
      logs_since++;
      return 1'b0;
    end
    // record due: never-written ring entries are zero and still count in the mean
    ring_sum = 0;
    foreach (mean_ring[i]) ring_sum += mean_ring[i];
    mean = ring_sum / RingDepth;
    r.addr  = next_addr[AddrW-1:0];
    r.tmin  = temp_lo[TempW-1:0];
    r.tmax  = temp_hi[TempW-1:0];
    r.tavg  = mean[TempW-1:0];
    r.batt  = s.batt;
    r.flags = s.flags;
    // wrap goes to base plus one record, not to base; address kept to 24 bits
    nxt = next_addr + RecBytes;
    if (nxt >= mem_limit) nxt = base_addr + RecBytes;
    next_addr = nxt & 32'h00FF_FFFF;
    logs_since = 0;
    return 1'b1;
  endfunction

  // gap or stall length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // temperatures: mostly a plausible band, some full-range, some at the edges
  function automatic logic signed [TempW-1:0] random_temp();
    int unsigned r;
    logic [31:0] raw;
    int          v;
    r   = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 70) begin
      v = int'($urandom_range(0, 6000)) - 3000;
      return v[TempW-1:0];
    end
    if (r < 90) return raw[TempW-1:0];
    case (raw[1:0])
      2'd0:    return 16'sh8000;
      2'd1:    return 16'sh7FFF;
      2'd2:    return 16'shFFFF;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [31:0] want_v,
                                      input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      flag_error($sformatf("record %0d %s: expected %0d, got %0d",
                           records_checked, name, want_v, got_v));
    end
  endfunction

  function automatic step_t cfg_step(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    step_t st;
    st = '0;
    st.kind    = StepCfg;
    st.reg_sel = idx;
    st.value   = v;
    return st;
  endfunction

  function automatic step_t snap_step(input logic signed [TempW-1:0] ta, tb, tc, td,
                                      input logic [BattW-1:0] batt,
                                      input logic [3:0] flags,
                                      input logic typed = 1'b0,
                                      input rec_t want = '0);
    step_t st;
    st = '0;
    st.kind  = StepSnap;
    st.snap  = '{ta, tb, tc, td, batt, flags};
    st.typed = typed;
    st.want  = want;
    return st;
  endfunction

  // park the sender, wait for every owed record, then let in-flight words settle
  task automatic quiesce();
    snap_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // register writes only ever happen with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
    reg_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // offer one snapshot word and hold it until taken; a typed row overrides the model's record
  task automatic send_snapshot(input snap_t s, input logic typed, input rec_t want);
    rec_t        r;
    int unsigned gap;
    snap_ch.valid           <= 1'b1;
    snap_ch.temp_a          <= s.ta;
    snap_ch.temp_b          <= s.tb;
    snap_ch.temp_c          <= s.tc;
    snap_ch.temp_d          <= s.td;
    snap_ch.battery_in      <= s.batt;
    snap_ch.mains_failed_in <= s.flags[3];
    snap_ch.charging_in     <= s.flags[2];
    snap_ch.compressor_in   <= s.flags[1];
    snap_ch.fan_in          <= s.flags[0];
    @(posedge clk_i);
    while (!snap_ch.ready) @(posedge clk_i);
    snapshots_sent++;
    if (predict_record(s, r)) pending_records.push_back(typed ? want : r);
    gap = src_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      snap_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit: a hang anywhere ends here
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d records still owed",
             cycle_cnt, pending_records.size());
    $display("sensor_stats_logger_unit_tb: errors");
    $finish;
  end

  // record sink: random back-pressure, long stalls now and then
  initial begin : record_sink
    int unsigned hold;
    rec_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        rec_ch.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
        rec_ch.ready <= (hold == 0);
      end else begin
        rec_ch.ready <= 1'b1;
      end
    end
  end

  // record checker: every taken record word against the oldest owed one
  initial begin : record_check
    rec_t got;
    rec_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rec_ch.valid && rec_ch.ready) begin
        got = '{rec_ch.write_address, rec_ch.min_temp_out, rec_ch.max_temp_out,
                rec_ch.avg_temp_out, rec_ch.battery_out,
                {rec_ch.mains_failed_out, rec_ch.charging_out,
                 rec_ch.compressor_out, rec_ch.fan_out}};
        if (pending_records.size() == 0) begin
          flag_error($sformatf("record at address 'h%06h with none owed", got.addr));
        end else begin
          want = pending_records.pop_front();
          check_field("write_address", {8'd0, want.addr}, {8'd0, got.addr});
          check_field("min_temp_out", want.tmin, got.tmin);
          check_field("max_temp_out", want.tmax, got.tmax);
          check_field("avg_temp_out", want.tavg, got.tavg);
          check_field("battery_out", {16'd0, want.batt}, {16'd0, got.batt});
          check_field("mains_failed_out", {31'd0, want.flags[3]}, {31'd0, got.flags[3]});
          check_field("charging_out", {31'd0, want.flags[2]}, {31'd0, got.flags[2]});
          check_field("compressor_out", {31'd0, want.flags[1]}, {31'd0, got.flags[1]});
          check_field("fan_out", {31'd0, want.flags[0]}, {31'd0, got.flags[0]});
        end
        records_checked++;
      end
    end
  end

  initial begin : stimulus
    step_t               dir_steps [$];
    snap_t               s;
    logic [CfgDataW-1:0] val;
    logic [3:0]          touch;
    int unsigned         r;
    int unsigned         n;
    int unsigned         ph;
    int unsigned         random_sent;
    int unsigned         directed_sent;
    int unsigned         waited;
    logic [31:0]         raw;

    // every block input known from time zero, reset held low
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CfgSamplePeriod;
    cfg_data_i              = '0;
    snap_ch.valid           = 1'b0;
    snap_ch.temp_a          = '0;
    snap_ch.temp_b          = '0;
    snap_ch.temp_c          = '0;
    snap_ch.temp_d          = '0;
    snap_ch.battery_in      = '0;
    snap_ch.mains_failed_in = 1'b0;
    snap_ch.charging_in     = 1'b0;
    snap_ch.compressor_in   = 1'b0;
    snap_ch.fan_in          = 1'b0;
    src_gaps                = 1'b1;
    sink_stalls             = 1'b1;
    snapshots_sent          = 0;
    records_checked         = 0;
    reg_writes              = 0;
    mismatches              = 0;
    random_sent             = 0;

    // model at its reset point
    sample_every  = SamplePeriodRst;
    log_every     = LogPeriodRst;
    base_addr     = BaseAddrRst;
    mem_limit     = MemSizeRst;
    samples_since = 0;
    logs_since    = 0;
    foreach (mean_ring[i]) mean_ring[i] = 0;
    ring_wr   = 0;
    temp_lo   = 0;
    temp_hi   = 0;
    next_addr = BaseAddrRst;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed table ----
    // log every word from the start, ring sampling still at its reset period:
    // the ring stays empty so the first records read off directly
    dir_steps.push_back(cfg_step(CfgLogPeriod, 25'd0));
    dir_steps.push_back(snap_step(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 4'b0000, 1'b1,
                        rec_t'{24'h000000, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 4'b0000}));
    // extremes grow from ordinary readings first
    dir_steps.push_back(snap_step(16'sd120, -16'sd40, 16'sd300, 16'sd7, 16'd1234, 4'b0100));
    dir_steps.push_back(snap_step(-16'sd250, 16'sd90, 16'sd15, 16'sd0, 16'd987, 4'b0011));
    // field maxima, then field minima
    dir_steps.push_back(snap_step(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF,
                        4'b1111, 1'b1,
                        rec_t'{24'd96, -16'sd250, 16'sh7FFF, 16'sd0, 16'hFFFF, 4'b1111}));
    dir_steps.push_back(snap_step(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h5555,
                        4'b1010, 1'b1,
                        rec_t'{24'd128, 16'sh8000, 16'sh7FFF, 16'sd0, 16'h5555, 4'b1010}));
    // sample every word: ring fills, partly-filled ring means, truncation toward zero
    dir_steps.push_back(cfg_step(CfgSamplePeriod, 25'd0));
    dir_steps.push_back(snap_step(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd1300, 4'b0001));
    dir_steps.push_back(snap_step(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd1299, 4'b0010));
    dir_steps.push_back(snap_step(-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'd1280, 4'b0100));
    dir_steps.push_back(snap_step(-16'sd3, -16'sd2, -16'sd2, -16'sd2, 16'd1275, 4'b1000));
    dir_steps.push_back(snap_step(16'sd5, 16'sd5, 16'sd5, -16'sd4, 16'd1270, 4'b0110));
    // address crosses the 24-bit top with a limit above it: plain modulo wrap
    dir_steps.push_back(cfg_step(CfgBaseAddr, 25'hFFFFC0));
    dir_steps.push_back(cfg_step(CfgMemSize, 25'h1FFFFFF));
    dir_steps.push_back(snap_step(16'sd2150, 16'sd2210, 16'sd1985, 16'sd2040, 16'd1260, 4'b1001));
    dir_steps.push_back(snap_step(16'sd2160, 16'sd2200, 16'sd1990, 16'sd2035, 16'd1255, 4'b0101));
    dir_steps.push_back(snap_step(16'sd2170, 16'sd2190, 16'sd1995, 16'sd2030, 16'd1250, 4'b0011));
    // zero memory limit: every address step jumps to base plus one record
    dir_steps.push_back(cfg_step(CfgMemSize, 25'd0));
    dir_steps.push_back(snap_step(-16'sd500, -16'sd480, -16'sd510, -16'sd495, 16'd1240, 4'b1100));
    dir_steps.push_back(snap_step(-16'sd505, -16'sd470, -16'sd515, -16'sd490, 16'd1235, 4'b0000));
    // smallest legal limit with base at zero: address sticks at one record
    dir_steps.push_back(cfg_step(CfgBaseAddr, 25'd0));
    dir_steps.push_back(cfg_step(CfgMemSize, 25'd32));
    dir_steps.push_back(snap_step(16'sd400, 16'sd410, 16'sd420, 16'sd430, 16'd1230, 4'b1110));
    dir_steps.push_back(snap_step(16'sd440, 16'sd450, 16'sd460, 16'sd470, 16'd1225, 4'b0111));
    // log period lowered under the running count: fires on the very next word
    dir_steps.push_back(cfg_step(CfgLogPeriod, 25'd5));
    dir_steps.push_back(snap_step(16'sd11, 16'sd12, 16'sd13, 16'sd14, 16'd1220, 4'b0001));
    dir_steps.push_back(snap_step(16'sd21, 16'sd22, 16'sd23, 16'sd24, 16'd1215, 4'b0010));
    dir_steps.push_back(snap_step(16'sd31, 16'sd32, 16'sd33, 16'sd34, 16'd1210, 4'b0100));
    dir_steps.push_back(snap_step(16'sd41, 16'sd42, 16'sd43, 16'sd44, 16'd1205, 4'b1000));
    dir_steps.push_back(cfg_step(CfgLogPeriod, 25'd1));
    dir_steps.push_back(snap_step(16'sd51, 16'sd52, 16'sd53, 16'sd54, 16'd1200, 4'b1111));

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == StepCfg) begin
        write_reg(dir_steps[i].reg_sel, dir_steps[i].value);
      end else begin
        send_snapshot(dir_steps[i].snap, dir_steps[i].typed, dir_steps[i].want);
      end
    end
    directed_sent = snapshots_sent;

    // ---- random phases, registers rewritten between them ----
    ph = 0;
    while (random_sent < RandomItems) begin
      if (ph == 0) begin
        // back to the reset settings
        write_reg(CfgSamplePeriod, SamplePeriodRst);
        write_reg(CfgLogPeriod, LogPeriodRst);
        write_reg(CfgBaseAddr, BaseAddrRst);
        write_reg(CfgMemSize, MemSizeRst);
      end else if (ph == 1) begin
        // ring frozen, a record per word, wrap at the top of the 24-bit space
        write_reg(CfgSamplePeriod, 25'd65535);
        write_reg(CfgLogPeriod, 25'd0);
        write_reg(CfgBaseAddr, 25'hFFFF00);
        write_reg(CfgMemSize, 25'h1000000);
      end else if (ph == 2) begin
        // longest log period: no records at all, next phase may lower it under the count
        write_reg(CfgSamplePeriod, 25'd0);
        write_reg(CfgLogPeriod, 25'd65535);
      end else begin
        touch = $urandom_range(1, 15);
        if (touch[0]) begin
          r = $urandom_range(0, 99);
          val = (r < 40) ? $urandom_range(0, 3) :
                (r < 70) ? $urandom_range(4, 15) :
                (r < 80) ? 25'd65535 :
                (r < 90) ? $urandom_range(16, 200) : $urandom_range(0, 65535);
          write_reg(CfgSamplePeriod, val);
        end
        if (touch[1]) begin
          r = $urandom_range(0, 99);
          val = (r < 50) ? $urandom_range(0, 3) :
                (r < 80) ? $urandom_range(4, 12) :
                (r < 88) ? 25'd65535 : $urandom_range(13, 80);
          write_reg(CfgLogPeriod, val);
        end
        if (touch[2]) begin
          r = $urandom_range(0, 99);
          val = (r < 30) ? 32 * $urandom_range(0, 64) :
                (r < 55) ? $urandom_range(0, 24'hFFFFFF) :
                (r < 70) ? 25'h1000000 - 32 * $urandom_range(1, 6) : 25'd0;
          write_reg(CfgBaseAddr, val);
        end
        if (touch[3]) begin
          r = $urandom_range(0, 99);
          // a limit a few records past base gives frequent in-range wraps
          val = (r < 35) ? base_addr + 32 * $urandom_range(1, 8) :
                (r < 50) ? 25'h1FFFFFF :
                (r < 60) ? MemSizeRst :
                (r < 70) ? $urandom_range(0, 31) :
                (r < 75) ? 25'h1000000 : $urandom_range(0, 25'h1FFFFFF);
          write_reg(CfgMemSize, val);
        end
      end

      // some phases run back-to-back on one side or both
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      n = $urandom_range(80, 160);
      if (n > RandomItems - random_sent) n = RandomItems - random_sent;

      for (int unsigned k = 0; k < n; k++) begin
        // mid-phase the sender sometimes holds off until every record is out
        if (k == n / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) quiesce();
        raw     = $urandom();
        s.ta    = random_temp();
        s.tb    = random_temp();
        s.tc    = random_temp();
        s.td    = random_temp();
        s.batt  = raw[31] ? raw[BattW-1:0] : BattW'($urandom_range(1050, 1450));
        s.flags = raw[19:16];
        send_snapshot(s, 1'b0, '0);
        random_sent++;
      end
      ph++;
    end

    // ---- wind down: collect the remaining records, then let the pipe settle ----
    snap_ch.valid <= 1'b0;
    waited = 0;
    while (pending_records.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Settle) @(posedge clk_i);
    if (pending_records.size() != 0) begin
      $display("%0d owed records never arrived", pending_records.size());
      mismatches += pending_records.size();
    end

    $display("ran %0d snapshot words (%0d directed) over %0d phases, %0d register writes",
             snapshots_sent, directed_sent, ph, reg_writes);
    $display("checked %0d log records field by field, %0d mismatches",
             records_checked, mismatches);
    if (mismatches == 0) begin
      $display("sensor_stats_logger_unit_tb: clean");
    end else begin
      $display("sensor_stats_logger_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ssl_pkg.sv
src/ssl_if.sv
src/ssl_ram.sv
src/ssl_fifo.sv
src/ssl_front.sv
src/ssl_back.sv
src/sensor_stats_logger_unit.sv
dv/sensor_stats_logger_unit_tb.sv
